// ===== src/fcnf_pkg.sv =====
// ----------------------------------------------------------------------------
// fcnf_pkg
// Shared types, reset values and saturation helpers for the friction
// contact node force pipeline.
// ----------------------------------------------------------------------------
package fcnf_pkg;

    localparam int DATA_W    = 32;
    localparam int COEF_W    = 31;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic        [COEF_W-1:0] coef_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_STIFFNESS    = 3'd0,
        CFG_TANGENT_STIFFNESS_X = 3'd1,
        CFG_TANGENT_STIFFNESS_Y = 3'd2,
        CFG_NORMAL_PRELOAD      = 3'd3,
        CFG_FRICTION_COEFF      = 3'd4
    } cfg_index_t;

    // reset values, Q16.16
    localparam coef_t NORMAL_STIFFNESS_RST = 31'd65536;
    localparam coef_t TANGENT_STIFFNESS_RST = 31'd65536;
    localparam data_t NORMAL_PRELOAD_RST   = 32'sd2621;
    localparam coef_t FRICTION_COEFF_RST   = 31'd13107;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    // per-item fields that ride alongside the divider lanes
    typedef struct packed {
        data_t force_x;
        data_t force_y;
        data_t force_n;
        data_t normal_prev;
        data_t disp_x;
        data_t disp_y;
        data_t prev_x;
        data_t prev_y;
        logic  slip_x;
        logic  slip_y;
        logic  neg_x;
        logic  neg_y;
    } side_t;

    // sign extend a data word to 64 bits
    function automatic logic signed [63:0] sext64(input data_t v);
        return {{(64-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    // saturate a 64 bit signed value into the data range
    function automatic data_t sat32(input logic signed [63:0] v);
        logic signed [63:0] r;
        priority if (v > SAT_MAX)
            r = SAT_MAX;
        else if (v < SAT_MIN)
            r = SAT_MIN;
        else
            r = v;
        return data_t'(r[DATA_W-1:0]);
    endfunction

endpackage

// ===== src/fcnf_divider.sv =====
// ----------------------------------------------------------------------------
// fcnf_divider
// Two-lane pipelined restoring divider, one quotient bit per stage, sharing
// one dividend; the item's side fields travel through the same stages.
// ----------------------------------------------------------------------------
module fcnf_divider #(
    parameter int DVD_W = 47
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [DVD_W-1:0]       dividend,
    input  fcnf_pkg::coef_t        divisor_x,
    input  fcnf_pkg::coef_t        divisor_y,
    input  fcnf_pkg::side_t        side_in,
    output logic                   out_valid,
    output logic [DVD_W-1:0]       quot_x,
    output logic [DVD_W-1:0]       quot_y,
    output fcnf_pkg::side_t        side_out
);
    import fcnf_pkg::*;

    // word: remaining dividend bits on top, quotient bits shifting in below
    logic [DVD_W-1:0]  word_reg [DVD_W][2];
    logic [COEF_W-1:0] rem_reg  [DVD_W][2];
    logic [DVD_W-1:0]  vld_reg;
    side_t             side_reg [DVD_W];

    coef_t divisor [2];
    assign divisor[0] = divisor_x;
    assign divisor[1] = divisor_y;

    for (genvar s = 0; s < DVD_W; s++)
    begin : g_stage
        // valid and side fields
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                if (s == 0)
                    vld_reg[s] <= in_valid;
                else
                    vld_reg[s] <= vld_reg[(s == 0) ? 0 : s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (s == 0)
                    side_reg[s] <= side_in;
                else
                    side_reg[s] <= side_reg[(s == 0) ? 0 : s-1];
            end
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [DVD_W-1:0]  word_src;
            logic [COEF_W-1:0] rem_src;
            logic [COEF_W:0]   trial;
            logic [COEF_W:0]   diff;
            logic              ge;
            logic [DVD_W-1:0]  word_next;
            logic [COEF_W-1:0] rem_next;

            if (s == 0)
            begin : g_first
                assign word_src = dividend;
                assign rem_src  = '0;
            end
            else
            begin : g_rest
                assign word_src = word_reg[s-1][l];
                assign rem_src  = rem_reg[s-1][l];
            end

            // one restoring step
            always_comb
            begin
                trial     = {rem_src, word_src[DVD_W-1]};
                diff      = trial - {1'b0, divisor[l]};
                ge        = (trial >= {1'b0, divisor[l]});
                rem_next  = ge ? diff[COEF_W-1:0] : trial[COEF_W-1:0];
                word_next = {word_src[DVD_W-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    word_reg[s][l] <= word_next;
                    rem_reg[s][l]  <= rem_next;
                end
            end
        end
    end

    assign out_valid = vld_reg[DVD_W-1];
    assign quot_x    = word_reg[DVD_W-1][0];
    assign quot_y    = word_reg[DVD_W-1][1];
    assign side_out  = side_reg[DVD_W-1];

endmodule

// ===== src/friction_contact_node_force.sv =====
// ----------------------------------------------------------------------------
// friction_contact_node_force
// Penalty normal force and Coulomb stick/slip tangential forces for one
// 3D contact node per transaction, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// One node enters per clock and one result leaves per clock while the
// output is taken; the block holds no state between nodes. From input
// to output register the path runs through four stages of
// multiply, saturate and compare, then a restoring divider that resolves
// one quotient bit per stage for the slider correction, then the output
// register. The whole pipeline holds when the output is full and not taken.
// Configuration is sampled along the pipeline and must only be written
// while no node is in flight.
module friction_contact_node_force #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic [fcnf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fcnf_pkg::DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  fcnf_pkg::data_t              disp_x,
    input  fcnf_pkg::data_t              disp_y,
    input  fcnf_pkg::data_t              disp_normal,
    input  fcnf_pkg::data_t              slider_x_prev,
    input  fcnf_pkg::data_t              slider_y_prev,
    input  fcnf_pkg::data_t              normal_prev,
    // output channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output fcnf_pkg::data_t              force_x,
    output fcnf_pkg::data_t              force_y,
    output fcnf_pkg::data_t              force_normal,
    output fcnf_pkg::data_t              slider_x,
    output fcnf_pkg::data_t              slider_y,
    output fcnf_pkg::data_t              normal_corr
);
    import fcnf_pkg::*;

    localparam int DVD_W = COEF_W + FRAC_BITS;
    localparam logic [DVD_W-1:0] Q_CLAMP = {{(DVD_W-32){1'b0}}, 32'h8000_0000};

    logic adv;

    // configuration registers
    coef_t normal_stiffness_reg;
    coef_t tangent_stiffness_x_reg;
    coef_t tangent_stiffness_y_reg;
    data_t normal_preload_reg;
    coef_t friction_coeff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_stiffness_reg    <= NORMAL_STIFFNESS_RST;
            tangent_stiffness_x_reg <= TANGENT_STIFFNESS_RST;
            tangent_stiffness_y_reg <= TANGENT_STIFFNESS_RST;
            normal_preload_reg      <= NORMAL_PRELOAD_RST;
            friction_coeff_reg      <= FRICTION_COEFF_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_NORMAL_STIFFNESS:    normal_stiffness_reg    <= cfg_data[COEF_W-1:0];
                CFG_TANGENT_STIFFNESS_X: tangent_stiffness_x_reg <= cfg_data[COEF_W-1:0];
                CFG_TANGENT_STIFFNESS_Y: tangent_stiffness_y_reg <= cfg_data[COEF_W-1:0];
                CFG_NORMAL_PRELOAD:      normal_preload_reg      <= data_t'(cfg_data);
                CFG_FRICTION_COEFF:      friction_coeff_reg      <= cfg_data[COEF_W-1:0];
                default:                 ;
            endcase
        end
    end

    // pipeline moves whenever the output register is free or being taken
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // valid bits for the arithmetic stages
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic div_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    // carried input fields
    data_t dx1_reg, dy1_reg, px1_reg, py1_reg, np1_reg;
    data_t dx2_reg, dy2_reg, px2_reg, py2_reg, np2_reg;
    data_t dx3_reg, dy3_reg, px3_reg, py3_reg, np3_reg;
    data_t dx4_reg, dy4_reg, px4_reg, py4_reg, np4_reg;

    // stage 1: normal product, tangential slips
    logic signed [63:0] pn_reg, pn_next;
    data_t slip_x1_reg, slip_x1_next;
    data_t slip_y1_reg, slip_y1_next;

    always_comb
    begin
        pn_next      = $signed({1'b0, normal_stiffness_reg}) * disp_normal;
        slip_x1_next = sat32(sext64(disp_x) - sext64(slider_x_prev));
        slip_y1_next = sat32(sext64(disp_y) - sext64(slider_y_prev));
    end

    // stage 2: normal force with zero floor, tangential products
    data_t n2_reg, n2_next;
    logic signed [63:0] ptx2_reg, ptx2_next;
    logic signed [63:0] pty2_reg, pty2_next;

    always_comb
    begin
        data_t qn;
        data_t nn;
        qn        = sat32(pn_reg >>> FRAC_BITS);
        nn        = sat32(sext64(normal_preload_reg) + sext64(qn));
        n2_next   = nn[DATA_W-1] ? '0 : nn;
        ptx2_next = $signed({1'b0, tangent_stiffness_x_reg}) * slip_x1_reg;
        pty2_next = $signed({1'b0, tangent_stiffness_y_reg}) * slip_y1_reg;
    end

    // stage 3: limit product, tangential trial forces, reported normal force
    logic signed [63:0] pl3_reg, pl3_next;
    data_t tx3_reg, tx3_next;
    data_t ty3_reg, ty3_next;
    data_t fn3_reg, fn3_next;

    always_comb
    begin
        pl3_next = $signed({1'b0, friction_coeff_reg}) * n2_reg;
        tx3_next = sat32(ptx2_reg >>> FRAC_BITS);
        ty3_next = sat32(pty2_reg >>> FRAC_BITS);
        fn3_next = sat32(sext64(n2_reg) - sext64(normal_preload_reg));
    end

    // stage 4: Coulomb limit and trial force magnitudes
    data_t limit4_reg, limit4_next;
    logic [DATA_W:0] magx4_reg, magx4_next;
    logic [DATA_W:0] magy4_reg, magy4_next;
    data_t tx4_reg, ty4_reg, fn4_reg;

    always_comb
    begin
        limit4_next = sat32(pl3_reg >>> FRAC_BITS);
        magx4_next  = tx3_reg[DATA_W-1] ? ((DATA_W+1)'(0) - {tx3_reg[DATA_W-1], tx3_reg})
                                        : {1'b0, tx3_reg};
        magy4_next  = ty3_reg[DATA_W-1] ? ((DATA_W+1)'(0) - {ty3_reg[DATA_W-1], ty3_reg})
                                        : {1'b0, ty3_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pn_reg      <= pn_next;
            slip_x1_reg <= slip_x1_next;
            slip_y1_reg <= slip_y1_next;
            dx1_reg     <= disp_x;
            dy1_reg     <= disp_y;
            px1_reg     <= slider_x_prev;
            py1_reg     <= slider_y_prev;
            np1_reg     <= normal_prev;

            n2_reg      <= n2_next;
            ptx2_reg    <= ptx2_next;
            pty2_reg    <= pty2_next;
            dx2_reg     <= dx1_reg;
            dy2_reg     <= dy1_reg;
            px2_reg     <= px1_reg;
            py2_reg     <= py1_reg;
            np2_reg     <= np1_reg;

            pl3_reg     <= pl3_next;
            tx3_reg     <= tx3_next;
            ty3_reg     <= ty3_next;
            fn3_reg     <= fn3_next;
            dx3_reg     <= dx2_reg;
            dy3_reg     <= dy2_reg;
            px3_reg     <= px2_reg;
            py3_reg     <= py2_reg;
            np3_reg     <= np2_reg;

            limit4_reg  <= limit4_next;
            magx4_reg   <= magx4_next;
            magy4_reg   <= magy4_next;
            tx4_reg     <= tx3_reg;
            ty4_reg     <= ty3_reg;
            fn4_reg     <= fn3_reg;
            dx4_reg     <= dx3_reg;
            dy4_reg     <= dy3_reg;
            px4_reg     <= px3_reg;
            py4_reg     <= py3_reg;
            np4_reg     <= np3_reg;
        end
    end

    // stick/slip decision and clamped forces, feeding the divider
    side_t             side5;
    logic [DVD_W-1:0]  dividend5;

    always_comb
    begin
        logic [DATA_W:0] lim_ext;
        lim_ext           = {1'b0, limit4_reg};
        side5.slip_x      = (magx4_reg > lim_ext);
        side5.slip_y      = (magy4_reg > lim_ext);
        side5.neg_x       = tx4_reg[DATA_W-1];
        side5.neg_y       = ty4_reg[DATA_W-1];
        side5.force_x     = side5.slip_x ? (side5.neg_x ? -limit4_reg : limit4_reg) : tx4_reg;
        side5.force_y     = side5.slip_y ? (side5.neg_y ? -limit4_reg : limit4_reg) : ty4_reg;
        side5.force_n     = fn4_reg;
        side5.normal_prev = np4_reg;
        side5.disp_x      = dx4_reg;
        side5.disp_y      = dy4_reg;
        side5.prev_x      = px4_reg;
        side5.prev_y      = py4_reg;
        dividend5         = {limit4_reg[COEF_W-1:0], {FRAC_BITS{1'b0}}};
    end

    // limit divided by each tangential stiffness
    logic [DVD_W-1:0] quot_x, quot_y;
    side_t            side_d;

    fcnf_divider #(
        .DVD_W (DVD_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s4_vld_reg),
        .dividend  (dividend5),
        .divisor_x (tangent_stiffness_x_reg),
        .divisor_y (tangent_stiffness_y_reg),
        .side_in   (side5),
        .out_valid (div_vld),
        .quot_x    (quot_x),
        .quot_y    (quot_y),
        .side_out  (side_d)
    );

    // corrected slider: displacement minus signed, saturated quotient
    function automatic data_t slide(input data_t disp, input logic [DVD_W-1:0] q,
                                    input logic neg);
        logic [31:0]        qc;
        logic signed [63:0] qv;
        qc = (q > Q_CLAMP) ? 32'h8000_0000 : q[31:0];
        qv = $signed({32'd0, qc});
        if (neg)
            qv = -qv;
        else if (qv > SAT_MAX)
            qv = SAT_MAX;
        return sat32(sext64(disp) - qv);
    endfunction

    // output register
    logic  out_valid_reg;
    data_t force_x_reg, force_y_reg, force_normal_reg;
    data_t slider_x_reg, slider_y_reg, normal_corr_reg;
    data_t slider_x_next, slider_y_next;

    always_comb
    begin
        slider_x_next = side_d.slip_x ? slide(side_d.disp_x, quot_x, side_d.neg_x)
                                      : side_d.prev_x;
        slider_y_next = side_d.slip_y ? slide(side_d.disp_y, quot_y, side_d.neg_y)
                                      : side_d.prev_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            force_x_reg      <= side_d.force_x;
            force_y_reg      <= side_d.force_y;
            force_normal_reg <= side_d.force_n;
            slider_x_reg     <= slider_x_next;
            slider_y_reg     <= slider_y_next;
            normal_corr_reg  <= side_d.normal_prev;
        end
    end

    assign out_valid    = out_valid_reg;
    assign force_x      = force_x_reg;
    assign force_y      = force_y_reg;
    assign force_normal = force_normal_reg;
    assign slider_x     = slider_x_reg;
    assign slider_y     = slider_y_reg;
    assign normal_corr  = normal_corr_reg;

endmodule

// ===== bench/friction_contact_node_force_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// friction_contact_node_force_tb
// Streams contact nodes through the friction force pipeline under random
// idling and back-pressure, predicts normal, tangential and slider values in
// Q16.16 per node, and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module friction_contact_node_force_tb;

    import fcnf_pkg::*;

    localparam int FRAC             = 16;
    localparam int RESET_CYCLES     = 9;
    localparam int PIPE_LATENCY     = 4 + 31 + FRAC + 1;
    localparam int SETTLE_CYCLES    = PIPE_LATENCY + 12;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD        = 300;
    localparam int MAX_GAP          = 17;
    localparam int RANDOM_BLOCKS    = 7;
    localparam int RANDOM_PER_BLOCK = 60;
    localparam int BURST_NODES      = 120;
    localparam int MAX_REPORTS      = 40;

    localparam data_t WORD_HI = 32'sh7FFF_FFFF;
    localparam data_t WORD_LO = 32'sh8000_0000;

    typedef struct packed {
        data_t disp_x;
        data_t disp_y;
        data_t disp_normal;
        data_t slider_x_prev;
        data_t slider_y_prev;
        data_t normal_prev;
    } node_t;

    typedef struct packed {
        data_t force_x;
        data_t force_y;
        data_t force_normal;
        data_t slider_x;
        data_t slider_y;
        data_t normal_corr;
    } contact_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    data_t                disp_x;
    data_t                disp_y;
    data_t                disp_normal;
    data_t                slider_x_prev;
    data_t                slider_y_prev;
    data_t                normal_prev;
    logic                 out_valid;
    logic                 out_ready;
    data_t                force_x;
    data_t                force_y;
    data_t                force_normal;
    data_t                slider_x;
    data_t                slider_y;
    data_t                normal_corr;

    // mirror of the configuration registers
    coef_t normal_k_reg   = NORMAL_STIFFNESS_RST;
    coef_t tangent_kx_reg = TANGENT_STIFFNESS_RST;
    coef_t tangent_ky_reg = TANGENT_STIFFNESS_RST;
    data_t preload_reg    = NORMAL_PRELOAD_RST;
    coef_t friction_reg   = FRICTION_COEFF_RST;

    contact_result_t pending_forces[$];

    int          tx_gap_max     = MAX_GAP;
    int          rx_stall_max   = MAX_GAP;
    bit          hold_request   = 1'b0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned nodes_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned reg_writes     = 0;
    int unsigned slipped_nodes  = 0;

    friction_contact_node_force #(
        .FRAC_BITS (FRAC)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .disp_x        (disp_x),
        .disp_y        (disp_y),
        .disp_normal   (disp_normal),
        .slider_x_prev (slider_x_prev),
        .slider_y_prev (slider_y_prev),
        .normal_prev   (normal_prev),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .force_x       (force_x),
        .force_y       (force_y),
        .force_normal  (force_normal),
        .slider_x      (slider_x),
        .slider_y      (slider_y),
        .normal_corr   (normal_corr)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // fixed-point force predictor
    // ------------------------------------------------------------------

    function automatic logic signed [63:0] clamp_word(input logic signed [63:0] v);
        if (v > SAT_MAX)
            return SAT_MAX;
        if (v < SAT_MIN)
            return SAT_MIN;
        return v;
    endfunction

    // coefficient times value, floor of the shifted product
    function automatic logic signed [63:0] q_scale(input coef_t k,
                                                  input logic signed [63:0] v);
        logic signed [63:0] p;
        p = $signed({33'd0, k}) * v;
        return clamp_word(p >>> FRAC);
    endfunction

    // force over stiffness, truncated toward zero, zero stiffness gives zero
    function automatic logic signed [63:0] q_unscale(input logic signed [63:0] t,
                                                    input coef_t k);
        logic [63:0]        mag;
        logic [63:0]        quo;
        logic signed [63:0] s;
        if (k == '0)
            return 0;
        mag = (t < 0) ? -t : t;
        quo = (mag << FRAC) / {33'd0, k};
        if (quo > 64'd2147483648)
            quo = 64'd2147483648;
        s = $signed(quo);
        return clamp_word((t < 0) ? -s : s);
    endfunction

    // stick or slip along one tangential axis
    function automatic void axis_response(input data_t disp, input data_t prev,
                                          input coef_t k, input logic signed [63:0] limit,
                                          output data_t force_o, output data_t slider_o);
        logic signed [63:0] d;
        logic signed [63:0] p;
        logic signed [63:0] t;
        logic signed [63:0] mag;
        d = disp;
        p = prev;
        t = q_scale(k, clamp_word(d - p));
        mag = (t < 0) ? -t : t;
        slider_o = prev;
        if (mag > limit)
        begin
            t = (t > 0) ? limit : -limit;
            slider_o = data_t'(clamp_word(d - q_unscale(t, k)));
        end
        force_o = data_t'(t);
    endfunction

    function automatic contact_result_t contact_forces(input node_t nd);
        logic signed [63:0] pre;
        logic signed [63:0] dn;
        logic signed [63:0] n;
        logic signed [63:0] limit;
        contact_result_t    r;
        pre = preload_reg;
        dn = nd.disp_normal;
        // penalty normal force, no tension
        n = clamp_word(pre + q_scale(normal_k_reg, dn));
        if (n < 0)
            n = 0;
        limit = q_scale(friction_reg, n);
        axis_response(nd.disp_x, nd.slider_x_prev, tangent_kx_reg, limit,
                      r.force_x, r.slider_x);
        axis_response(nd.disp_y, nd.slider_y_prev, tangent_ky_reg, limit,
                      r.force_y, r.slider_y);
        r.force_normal = data_t'(clamp_word(n - pre));
        r.normal_corr = nd.normal_prev;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic node_t make_node(input data_t dx, input data_t dy, input data_t dn,
                                        input data_t px, input data_t py, input data_t np);
        node_t nd;
        nd.disp_x = dx;
        nd.disp_y = dy;
        nd.disp_normal = dn;
        nd.slider_x_prev = px;
        nd.slider_y_prev = py;
        nd.normal_prev = np;
        return nd;
    endfunction

    // signed value within plus or minus 2^span_bits
    function automatic data_t near_value(input int unsigned span_bits);
        int m;
        m = 1 << span_bits;
        return data_t'(int'($urandom_range(0, 2 * m)) - m);
    endfunction

    // mostly displacements near the slider, some raw words
    function automatic node_t random_node();
        node_t nd;
        if ($urandom_range(0, 7) == 0)
        begin
            nd = make_node($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        else
        begin
            nd.slider_x_prev = near_value(24);
            nd.slider_y_prev = near_value(24);
            nd.disp_x = nd.slider_x_prev + near_value($urandom_range(0, 22));
            nd.disp_y = nd.slider_y_prev + near_value($urandom_range(0, 22));
            nd.disp_normal = near_value($urandom_range(0, 22));
            nd.normal_prev = $urandom;
        end
        return nd;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        reg_writes++;
        // only the low 31 bits of a coefficient are kept
        case (idx)
            CFG_NORMAL_STIFFNESS:    normal_k_reg = value[COEF_W-1:0];
            CFG_TANGENT_STIFFNESS_X: tangent_kx_reg = value[COEF_W-1:0];
            CFG_TANGENT_STIFFNESS_Y: tangent_ky_reg = value[COEF_W-1:0];
            CFG_NORMAL_PRELOAD:      preload_reg = value;
            CFG_FRICTION_COEFF:      friction_reg = value[COEF_W-1:0];
            default:                 ;
        endcase
    endtask

    // one input transaction, after a random gap
    task automatic send_node(input node_t nd);
        contact_result_t want;
        int              gap;
        gap = $urandom_range(0, tx_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        disp_x <= nd.disp_x;
        disp_y <= nd.disp_y;
        disp_normal <= nd.disp_normal;
        slider_x_prev <= nd.slider_x_prev;
        slider_y_prev <= nd.slider_y_prev;
        normal_prev <= nd.normal_prev;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        want = contact_forces(nd);
        pending_forces = {pending_forces, want};
        nodes_sent++;
        if (want.slider_x != nd.slider_x_prev || want.slider_y != nd.slider_y_prev)
            slipped_nodes++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic await_all_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_forces.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_corners();
        send_node(make_node(WORD_HI, WORD_LO, WORD_HI, WORD_LO, WORD_HI, WORD_HI));
        send_node(make_node(WORD_LO, WORD_HI, WORD_LO, WORD_HI, WORD_LO, WORD_LO));
        send_node(make_node(0, 0, 0, 0, 0, 0));
    endtask

    task automatic randomize_config(input bit wide);
        logic [DATA_W-1:0] ns;
        logic [DATA_W-1:0] kx;
        logic [DATA_W-1:0] ky;
        logic [DATA_W-1:0] pre;
        logic [DATA_W-1:0] fc;
        if (wide)
        begin
            ns = $urandom;
            kx = $urandom | 32'd1;
            ky = $urandom | 32'd1;
            pre = $urandom;
            fc = $urandom;
        end
        else
        begin
            // moderate values so both stick and slip show up
            ns = {1'($urandom_range(0, 1)), 31'($urandom_range(0, 1 << 20))};
            kx = {1'($urandom_range(0, 1)), 31'($urandom_range(1, 1 << 20))};
            ky = {1'($urandom_range(0, 1)), 31'($urandom_range(1, 1 << 20))};
            pre = 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            fc = {1'($urandom_range(0, 1)), 31'($urandom_range(0, 1 << 17))};
        end
        write_reg(CFG_NORMAL_STIFFNESS, ns);
        write_reg(CFG_TANGENT_STIFFNESS_X, kx);
        write_reg(CFG_TANGENT_STIFFNESS_Y, ky);
        write_reg(CFG_NORMAL_PRELOAD, pre);
        write_reg(CFG_FRICTION_COEFF, fc);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset configuration: limit exactly reached, slip, no contact, corners
    task automatic test_reset_defaults();
        send_node(make_node(65535, -65536, 325059, 0, 0, 32'sh1234_5678));
        send_node(make_node(66536, -65035, 325059, 1000, 500, -7));
        send_node(make_node(1, 5, -1048576, 0, 5, 0));
        send_corners();
    endtask

    // register extremes, coefficient masking, zero stiffness, unused indexes
    task automatic test_register_extremes();
        await_all_results();
        write_reg(CFG_NORMAL_STIFFNESS, 32'h7FFF_FFFF);
        write_reg(CFG_TANGENT_STIFFNESS_X, 32'hFFFF_FFFF);
        write_reg(CFG_TANGENT_STIFFNESS_Y, 32'h0000_0001);
        write_reg(CFG_NORMAL_PRELOAD, WORD_HI);
        write_reg(CFG_FRICTION_COEFF, 32'h7FFF_FFFF);
        send_corners();

        await_all_results();
        write_reg(CFG_NORMAL_STIFFNESS, 32'h0000_0000);
        write_reg(CFG_TANGENT_STIFFNESS_X, 32'h0000_0000);
        write_reg(CFG_TANGENT_STIFFNESS_Y, 32'h8000_0000);
        write_reg(CFG_NORMAL_PRELOAD, WORD_LO);
        write_reg(CFG_FRICTION_COEFF, 32'h8000_0000);
        send_corners();

        await_all_results();
        write_reg(CFG_NORMAL_STIFFNESS, 32'h0001_8000);
        write_reg(CFG_TANGENT_STIFFNESS_X, 32'h0000_4000);
        write_reg(CFG_TANGENT_STIFFNESS_Y, 32'h0002_0000);
        write_reg(CFG_NORMAL_PRELOAD, 32'hFFFF_0000);
        write_reg(CFG_FRICTION_COEFF, 32'h0000_8000);
        // writes to unused indexes must leave everything unchanged
        for (int i = CFG_FRICTION_COEFF + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), $urandom);
        send_corners();
        send_node(make_node(32'sh0010_0000, -32'sh0010_0000, 32'sh0002_0000, 0, 0, 1));
    endtask

    // random nodes in blocks, new configuration and idling mix per block
    task automatic test_random_nodes();
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            await_all_results();
            randomize_config(blk % 3 == 2);
            case (blk % 4)
                0: begin tx_gap_max = MAX_GAP; rx_stall_max = MAX_GAP; end
                1: begin tx_gap_max = 0;       rx_stall_max = 0;       end
                2: begin tx_gap_max = 0;       rx_stall_max = MAX_GAP; end
                default: begin tx_gap_max = MAX_GAP; rx_stall_max = 0; end
            endcase
            repeat (RANDOM_PER_BLOCK)
                send_node(random_node());
        end
    endtask

    // long receiver hold with a full-rate sender, then a drained pause
    task automatic test_backpressure();
        await_all_results();
        tx_gap_max = 0;
        rx_stall_max = 0;
        hold_request = 1'b1;
        repeat (BURST_NODES)
            send_node(random_node());
        await_all_results();
        tx_gap_max = MAX_GAP;
        rx_stall_max = MAX_GAP;
        repeat (BURST_NODES / 3)
            send_node(random_node());
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // ready with random stalls, long hold on request
    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                stall = LONG_HOLD;
                hold_request = 1'b0;
            end
            else
            begin
                stall = $urandom_range(0, rx_stall_max);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    task automatic check_field(input string name, input data_t got, input data_t want);
        if (got !== want)
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : result_check
        contact_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            results_seen++;
            if (pending_forces.size() == 0)
            begin
                report_error("result transaction with no node outstanding");
            end
            else
            begin
                want = pending_forces.pop_front();
                check_field("force_x", force_x, want.force_x);
                check_field("force_y", force_y, want.force_y);
                check_field("force_normal", force_normal, want.force_normal);
                check_field("slider_x", slider_x, want.slider_x);
                check_field("slider_y", slider_y, want.slider_y);
                check_field("normal_corr", normal_corr, want.normal_corr);
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        disp_x = '0;
        disp_y = '0;
        disp_normal = '0;
        slider_x_prev = '0;
        slider_y_prev = '0;
        normal_prev = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_nodes();
        test_backpressure();

        // let any stray result show up
        await_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_forces.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_forces.size()));

        $display("covered %0d nodes and %0d results over %0d register writes",
                 nodes_sent, results_seen, reg_writes);
        $display("%0d nodes slipped; one %0d-cycle output hold stalled the input",
                 slipped_nodes, LONG_HOLD);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
src/fcnf_pkg.sv
src/fcnf_divider.sv
src/friction_contact_node_force.sv
bench/friction_contact_node_force_tb.sv
